// ===== design/sphdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sphdp_pkg
// Shared types, constants and kernel tables for the SPH density unit.
// ----------------------------------------------------------------------------
package sphdp_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned SUM_WIDTH_DEF  = 48;
  localparam int unsigned SQRT_ITER_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned SCALE_FRAC     = 24;

  localparam logic [2:0] REG_KIND     = 3'd0;
  localparam logic [2:0] REG_INV_H    = 3'd1;
  localparam logic [2:0] REG_SCALE    = 3'd2;
  localparam logic [2:0] REG_STIFF    = 3'd3;
  localparam logic [2:0] REG_INV_RHO0 = 3'd4;

  localparam logic        KIND_RST     = 1'b0;
  localparam logic [31:0] INV_H_RST    = 32'd65536;
  localparam logic [31:0] SCALE_RST    = 32'd16777216;
  localparam logic [31:0] STIFF_RST    = 32'd65536;
  localparam logic [31:0] INV_RHO0_RST = 32'd65536;

  localparam logic KIND_CUBIC   = 1'b0;
  localparam logic KIND_QUINTIC = 1'b1;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] mass;
    logic        last;
  } sphdp_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] inv_h;
    logic [31:0] scale;
    logic [31:0] stiff;
    logic [31:0] inv_rho0;
  } sphdp_cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } sphdp_mul_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] p;
  } sphdp_mul_rsp_t;

  // spline term t: (base - q)^e * coef
  function automatic logic [1:0] term_base(logic kind, logic [1:0] t);
    logic [1:0] b;
    b = (kind == KIND_QUINTIC) ? 2'(2'd3 - t) : 2'(2'd2 - t);
    return b;
  endfunction

  function automatic logic [3:0] coef_mag(logic kind, logic [1:0] t);
    logic [3:0] m;
    case (t)
      2'd0:    m = 4'd1;
      2'd1:    m = (kind == KIND_QUINTIC) ? 4'd6 : 4'd4;
      2'd2:    m = 4'd15;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  function automatic logic coef_neg(logic [1:0] t);
    return (t == 2'd1);
  endfunction

  function automatic logic [1:0] last_term(logic kind);
    return (kind == KIND_QUINTIC) ? 2'd2 : 2'd1;
  endfunction

  function automatic logic [1:0] last_pow(logic kind);
    return (kind == KIND_QUINTIC) ? 2'd3 : 2'd1;
  endfunction

endpackage

// ===== design/sphdp_in_if.sv =====
// ----------------------------------------------------------------------------
// sphdp_in_if
// Neighbour channel: offsets, mass and last marker per beat.
// ----------------------------------------------------------------------------
interface sphdp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic        [31:0] neighbour_mass;
  logic               last_neighbour;

  modport source (output valid, offset_x, offset_y, offset_z, neighbour_mass,
                  last_neighbour, input ready);
  modport sink   (input valid, offset_x, offset_y, offset_z, neighbour_mass,
                  last_neighbour, output ready);
endinterface

// ===== design/sphdp_out_if.sv =====
// ----------------------------------------------------------------------------
// sphdp_out_if
// Result channel: density, pressure and clip flag per beat.
// ----------------------------------------------------------------------------
interface sphdp_out_if;
  logic               valid;
  logic               ready;
  logic        [47:0] density;
  logic signed [47:0] pressure;
  logic               saturated;

  modport source (output valid, density, pressure, saturated, input ready);
  modport sink   (input valid, density, pressure, saturated, output ready);
endinterface

// ===== design/sphdp_front.sv =====
// ----------------------------------------------------------------------------
// sphdp_front
// Takes neighbour beats and forms offset magnitudes for the queue.
// ----------------------------------------------------------------------------
module sphdp_front (
  sphdp_in_if.sink            in_i,
  output logic                push_valid_o,
  output sphdp_pkg::sphdp_item_t push_item_o,
  input  logic                push_ready_i
);
  import sphdp_pkg::*;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

  assign in_i.ready        = push_ready_i;
  assign push_valid_o      = in_i.valid;
  assign push_item_o.ax    = mag32(in_i.offset_x);
  assign push_item_o.ay    = mag32(in_i.offset_y);
  assign push_item_o.az    = mag32(in_i.offset_z);
  assign push_item_o.mass  = in_i.neighbour_mass;
  assign push_item_o.last  = in_i.last_neighbour;

endmodule

// ===== design/sphdp_fifo.sv =====
// ----------------------------------------------------------------------------
// sphdp_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module sphdp_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  input  sphdp_pkg::sphdp_item_t push_item_i,
  output logic                   push_ready_o,
  input  logic                   pop_i,
  output logic                   pop_valid_o,
  output sphdp_pkg::sphdp_item_t pop_item_o
);
  import sphdp_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  sphdp_item_t     mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = push ? PW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? PW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/sphdp_mul.sv =====
// ----------------------------------------------------------------------------
// sphdp_mul
// Shared 64x64 multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module sphdp_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sphdp_pkg::sphdp_mul_req_t req_i,
  output sphdp_pkg::sphdp_mul_rsp_t rsp_o
);
  import sphdp_pkg::*;

  logic         run_q, done_q, short_q;
  logic [1:0]   step_q;
  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic         fin;

  always_comb begin
    case (step_q)
      2'd0:    begin ah = a_q[31:0];  bh = b_q[31:0];  end
      2'd1:    begin ah = a_q[31:0];  bh = b_q[63:32]; end
      2'd2:    begin ah = a_q[63:32]; bh = b_q[31:0];  end
      default: begin ah = a_q[63:32]; bh = b_q[63:32]; end
    endcase
  end

  assign pp = 64'(ah) * 64'(bh);

  always_comb begin
    case (step_q)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  assign fin = run_q && (short_q || step_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= fin;
      if (req_i.start) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= 2'(step_q + 1'b1);
        if (fin) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q     <= req_i.a;
      b_q     <= req_i.b;
      short_q <= (req_i.a[63:32] == '0) && (req_i.b[63:32] == '0);
      acc_q   <= '0;
    end else if (run_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

// ===== design/sphdp_back.sv =====
// ----------------------------------------------------------------------------
// sphdp_back
// Sequencer: distance, kernel, accumulation and Tait pressure.
// ----------------------------------------------------------------------------
module sphdp_back #(
  parameter int unsigned FRAC_BITS       = sphdp_pkg::FRAC_BITS_DEF,
  parameter int unsigned SUM_WIDTH       = sphdp_pkg::SUM_WIDTH_DEF,
  parameter int unsigned SQRT_ITERATIONS = sphdp_pkg::SQRT_ITER_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sphdp_pkg::sphdp_cfg_t     cfg_i,
  input  logic                      item_valid_i,
  input  sphdp_pkg::sphdp_item_t    item_i,
  output logic                      pop_o,
  output sphdp_pkg::sphdp_mul_req_t mul_req_o,
  input  sphdp_pkg::sphdp_mul_rsp_t mul_rsp_i,
  sphdp_out_if.source               out_o
);
  import sphdp_pkg::*;

  localparam int unsigned ROOT_STEPS = (SQRT_ITERATIONS < 32) ? SQRT_ITERATIONS : 32;
  localparam int unsigned ROOT_PAD   = 32 - ROOT_STEPS;
  localparam logic [63:0] ONE        = 64'(1) << FRAC_BITS;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;
  localparam logic [63:0] OUT48_MAX  = (64'(1) << 48) - 64'd1;
  localparam logic [63:0] POS47_MAX  = (64'(1) << 47) - 64'd1;
  localparam logic [63:0] BIG63_MAX  = (64'(1) << 63) - 64'd1;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SQ   = 12'b0000_0000_0010,
    S_ROOT = 12'b0000_0000_0100,
    S_QMUL = 12'b0000_0000_1000,
    S_TERM = 12'b0000_0001_0000,
    S_POW  = 12'b0000_0010_0000,
    S_WMUL = 12'b0000_0100_0000,
    S_CMUL = 12'b0000_1000_0000,
    S_RAT  = 12'b0001_0000_0000,
    S_PMUL = 12'b0010_0000_0000,
    S_EMIT = 12'b0100_0000_0000,
    S_SPARE = 12'b1000_0000_0000
  } sphdp_state_e;

  sphdp_state_e st_q, st_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [1:0]   term_q, term_d;
  logic [31:0]  ay_q, ay_d, az_q, az_d, mass_q, mass_d;
  logic         last_q, last_d;
  logic [63:0]  ss_q, ss_d, v_q, v_d;
  logic [35:0]  rem_q, rem_d;
  logic [31:0]  root_q, root_d;
  logic [63:0]  qv_q, qv_d, u_q, u_d, shape_q, shape_d;
  logic [63:0]  ratio_q, ratio_d;
  logic         pos_q, pos_d;
  logic [47:0]  rho_q, rho_d, pres_q, pres_d;
  logic [SUM_WIDTH-1:0] sum_q, sum_d;
  logic         clip_q, clip_d;
  logic         out_vld_q, out_vld_d, load;
  logic [47:0]  dens_o_q, pres_o_q;
  logic         sat_o_q;

  logic [127:0] psh;
  logic [35:0]  rem_sh, trial;
  logic         root_take;
  logic [31:0]  root_nx;
  logic [63:0]  base_fx, pow_nx, term_val, shape_pos;
  logic         contrib_sat;
  logic [SUM_WIDTH-1:0] contrib, sum_nx;
  logic [SUM_WIDTH:0]   acc_sum;
  logic [63:0]  sum_wide;
  logic         rho_sat;
  logic [47:0]  rho_nx;
  logic         big_sat;
  logic [63:0]  big_nx, ratio_nx;
  logic         pos_sat;

  assign psh         = mul_rsp_i.p >> FRAC_BITS;
  assign rem_sh      = {rem_q[33:0], v_q[63:62]};
  assign trial       = {2'b00, root_q, 2'b01};
  assign root_take   = (rem_sh >= trial);
  assign root_nx     = {root_q[30:0], root_take};
  assign base_fx     = 64'(term_base(cfg_i.kind, term_q)) << FRAC_BITS;
  assign pow_nx      = psh[63:0];
  assign term_val    = pow_nx * 64'(coef_mag(cfg_i.kind, term_q));
  assign shape_pos   = shape_q[63] ? '0 : shape_q;
  assign contrib_sat = (psh > 128'(SUM_MAX));
  assign contrib     = contrib_sat ? SUM_MAX : psh[SUM_WIDTH-1:0];
  assign acc_sum     = {1'b0, sum_q} + {1'b0, contrib};
  assign sum_nx      = acc_sum[SUM_WIDTH] ? SUM_MAX : acc_sum[SUM_WIDTH-1:0];
  assign sum_wide    = 64'(sum_nx);
  assign rho_sat     = (sum_wide > OUT48_MAX);
  assign rho_nx      = rho_sat ? OUT48_MAX[47:0] : sum_wide[47:0];
  assign big_sat     = (psh[127:63] != '0);
  assign big_nx      = big_sat ? BIG63_MAX : psh[63:0];
  assign ratio_nx    = (cnt_q == '0) ? big_nx : ratio_q;
  assign pos_sat     = (psh > 128'(POS47_MAX));

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    term_d    = term_q;
    ay_d      = ay_q;
    az_d      = az_q;
    mass_d    = mass_q;
    last_d    = last_q;
    ss_d      = ss_q;
    v_d       = v_q;
    rem_d     = rem_q;
    root_d    = root_q;
    qv_d      = qv_q;
    u_d       = u_q;
    shape_d   = shape_q;
    ratio_d   = ratio_q;
    pos_d     = pos_q;
    rho_d     = rho_q;
    pres_d    = pres_q;
    sum_d     = sum_q;
    clip_d    = clip_q;
    load      = 1'b0;
    pop_o     = 1'b0;
    mul_req_o = '0;
    out_vld_d = out_vld_q && !out_o.ready;

    case (st_q)
      S_IDLE: begin
        if (item_valid_i) begin
          pop_o           = 1'b1;
          ay_d            = item_i.ay;
          az_d            = item_i.az;
          mass_d          = item_i.mass;
          last_d          = item_i.last;
          ss_d            = '0;
          cnt_d           = '0;
          mul_req_o.start = 1'b1;
          mul_req_o.a     = 64'(item_i.ax);
          mul_req_o.b     = 64'(item_i.ax);
          st_d            = S_SQ;
        end
      end
      S_SQ: begin
        if (mul_rsp_i.done) begin
          ss_d = ss_q + mul_rsp_i.p[63:0];
          if (cnt_q == 6'd2) begin
            v_d    = ss_q + mul_rsp_i.p[63:0];
            rem_d  = '0;
            root_d = '0;
            cnt_d  = '0;
            st_d   = S_ROOT;
          end else begin
            cnt_d           = cnt_q + 6'd1;
            mul_req_o.start = 1'b1;
            mul_req_o.a     = 64'((cnt_q == '0) ? ay_q : az_q);
            mul_req_o.b     = 64'((cnt_q == '0) ? ay_q : az_q);
          end
        end
      end
      S_ROOT: begin
        rem_d  = root_take ? 36'(rem_sh - trial) : rem_sh;
        root_d = root_nx;
        v_d    = v_q << 2;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'(ROOT_STEPS - 1)) begin
          mul_req_o.start = 1'b1;
          mul_req_o.a     = 64'(root_nx << ROOT_PAD);
          mul_req_o.b     = 64'(cfg_i.inv_h);
          st_d            = S_QMUL;
        end
      end
      S_QMUL: begin
        if (mul_rsp_i.done) begin
          qv_d    = psh[63:0];
          term_d  = '0;
          shape_d = '0;
          st_d    = S_TERM;
        end
      end
      S_TERM: begin
        if (term_q > last_term(cfg_i.kind)) begin
          mul_req_o.start = 1'b1;
          mul_req_o.a     = shape_pos;
          mul_req_o.b     = 64'(cfg_i.scale);
          st_d            = S_WMUL;
        end else if (qv_q <= base_fx) begin
          u_d             = base_fx - qv_q;
          cnt_d           = '0;
          mul_req_o.start = 1'b1;
          mul_req_o.a     = base_fx - qv_q;
          mul_req_o.b     = base_fx - qv_q;
          st_d            = S_POW;
        end else begin
          term_d = term_q + 2'd1;
        end
      end
      S_POW: begin
        if (mul_rsp_i.done) begin
          if (cnt_q == 6'(last_pow(cfg_i.kind))) begin
            shape_d = coef_neg(term_q) ? shape_q - term_val : shape_q + term_val;
            term_d  = term_q + 2'd1;
            st_d    = S_TERM;
          end else begin
            cnt_d           = cnt_q + 6'd1;
            mul_req_o.start = 1'b1;
            mul_req_o.a     = pow_nx;
            mul_req_o.b     = u_q;
          end
        end
      end
      S_WMUL: begin
        if (mul_rsp_i.done) begin
          mul_req_o.start = 1'b1;
          mul_req_o.a     = 64'(mass_q);
          mul_req_o.b     = mul_rsp_i.p[SCALE_FRAC +: 64];
          st_d            = S_CMUL;
        end
      end
      S_CMUL: begin
        if (mul_rsp_i.done) begin
          sum_d  = sum_nx;
          clip_d = clip_q | contrib_sat | acc_sum[SUM_WIDTH];
          if (last_q) begin
            rho_d           = rho_nx;
            clip_d          = clip_q | contrib_sat | acc_sum[SUM_WIDTH] | rho_sat;
            cnt_d           = '0;
            mul_req_o.start = 1'b1;
            mul_req_o.a     = 64'(rho_nx);
            mul_req_o.b     = 64'(cfg_i.inv_rho0);
            st_d            = S_RAT;
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      S_RAT: begin
        if (mul_rsp_i.done) begin
          clip_d  = clip_q | big_sat;
          ratio_d = ratio_nx;
          mul_req_o.start = 1'b1;
          if (cnt_q == 6'd6) begin
            pos_d       = (big_nx >= ONE);
            mul_req_o.a = 64'(cfg_i.stiff);
            mul_req_o.b = (big_nx >= ONE) ? big_nx - ONE : ONE - big_nx;
            st_d        = S_PMUL;
          end else begin
            cnt_d       = cnt_q + 6'd1;
            mul_req_o.a = big_nx;
            mul_req_o.b = ratio_nx;
          end
        end
      end
      S_PMUL: begin
        if (mul_rsp_i.done) begin
          if (pos_q) begin
            pres_d = pos_sat ? POS47_MAX[47:0] : psh[47:0];
            clip_d = clip_q | pos_sat;
          end else begin
            pres_d = 48'(48'd0 - psh[47:0]);
          end
          st_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          load      = 1'b1;
          out_vld_d = 1'b1;
          sum_d     = '0;
          clip_d    = 1'b0;
          st_d      = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      cnt_q     <= '0;
      term_q    <= '0;
      sum_q     <= '0;
      clip_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      term_q    <= term_d;
      sum_q     <= sum_d;
      clip_q    <= clip_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ay_q    <= ay_d;
    az_q    <= az_d;
    mass_q  <= mass_d;
    last_q  <= last_d;
    ss_q    <= ss_d;
    v_q     <= v_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    qv_q    <= qv_d;
    u_q     <= u_d;
    shape_q <= shape_d;
    ratio_q <= ratio_d;
    pos_q   <= pos_d;
    rho_q   <= rho_d;
    pres_q  <= pres_d;
    if (load) begin
      dens_o_q <= rho_q;
      pres_o_q <= pres_q;
      sat_o_q  <= clip_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.density   = dens_o_q;
  assign out_o.pressure  = pres_o_q;
  assign out_o.saturated = sat_o_q;

endmodule

// ===== design/sph_density_and_pressure_unit.sv =====
// ----------------------------------------------------------------------------
// sph_density_and_pressure_unit
// SPH density summation with cubic/quintic spline and Tait pressure.
//
//  channel   dir  beat
//  in_i      in   neighbour offsets, mass, last marker
//  out_o     out  density, pressure, saturated (on last neighbour only)
//  apb       in   kernel_kind, inv_smoothing_length, kernel_scale,
//                 stiffness, inv_rest_density at 0x0..0x10
//
// Each neighbour takes longer with the quintic kernel than with the cubic one; its
// time is set by the one-bit-a-cycle square root (min(SQRT_ITERATIONS,32) root
// steps) and the shared multiplier, which skips the upper partial products when both operands fit in 32 bits.
// The last neighbour adds the seven-fold ratio power.
// A four-beat queue keeps taking neighbours until it is full while the sequencer
// works or a result waits. Reset clears the sum, the clip flag and all control.
// ----------------------------------------------------------------------------
module sph_density_and_pressure_unit #(
  parameter int unsigned FRAC_BITS       = sphdp_pkg::FRAC_BITS_DEF,
  parameter int unsigned SUM_WIDTH       = sphdp_pkg::SUM_WIDTH_DEF,
  parameter int unsigned SQRT_ITERATIONS = sphdp_pkg::SQRT_ITER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sphdp_in_if.sink    in_i,
  sphdp_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sphdp_pkg::*;

  sphdp_cfg_t     cfg_q;
  sphdp_item_t    push_item, pop_item;
  logic           push_valid, push_ready, q_pop, q_valid;
  sphdp_mul_req_t mul_req;
  sphdp_mul_rsp_t mul_rsp;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind     <= KIND_RST;
      cfg_q.inv_h    <= INV_H_RST;
      cfg_q.scale    <= SCALE_RST;
      cfg_q.stiff    <= STIFF_RST;
      cfg_q.inv_rho0 <= INV_RHO0_RST;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_KIND:     cfg_q.kind     <= pwdata[0];
        REG_INV_H:    cfg_q.inv_h    <= pwdata;
        REG_SCALE:    cfg_q.scale    <= pwdata;
        REG_STIFF:    cfg_q.stiff    <= pwdata;
        REG_INV_RHO0: cfg_q.inv_rho0 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_KIND:     prdata = 32'(cfg_q.kind);
      REG_INV_H:    prdata = cfg_q.inv_h;
      REG_SCALE:    prdata = cfg_q.scale;
      REG_STIFF:    prdata = cfg_q.stiff;
      REG_INV_RHO0: prdata = cfg_q.inv_rho0;
      default:      prdata = '0;
    endcase
  end

  sphdp_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  sphdp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_item_o   (pop_item)
  );

  sphdp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  sphdp_back #(
    .FRAC_BITS       (FRAC_BITS),
    .SUM_WIDTH       (SUM_WIDTH),
    .SQRT_ITERATIONS (SQRT_ITERATIONS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (pop_item),
    .pop_o        (q_pop),
    .mul_req_o    (mul_req),
    .mul_rsp_i    (mul_rsp),
    .out_o        (out_o)
  );

  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_mul_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy) else $error("multiplier started while busy");

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |=> !mul_rsp.done) else $error("multiplier done held");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the SPH density and pressure unit. A directed table of neighbours
// is sent first, followed by random particles over several register
// settings. Each result beat is compared against an in-bench model of the
// fixed-point density sum, the kernel and the Tait pressure. Both channels
// stall at random, and the configuration is rewritten over APB between
// particles.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sphdp_pkg::*;

  localparam logic [63:0] ONE       = 64'd65536;
  localparam logic [63:0] SUM_MAX   = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] POS47_MAX = (64'd1 << 47) - 64'd1;
  localparam logic [63:0] BIG63_MAX = (64'd1 << 63) - 64'd1;
  localparam int          IDLE_WAIT = 600;
  localparam int          WDOG_MAX  = 20000;

  typedef struct {
    logic [47:0] density;
    logic [47:0] pressure;
    logic        saturated;
  } particle_res_t;

  typedef struct {
    logic        kind;
    logic [31:0] ox, oy, oz, mass;
    logic        last;
    bit          typed;
    logic [47:0] rho, pres;
    logic        sat;
  } nb_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sphdp_in_if  nb_ch ();
  sphdp_out_if res_ch ();

  sph_density_and_pressure_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(nb_ch), .out_o(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  // model state
  logic        m_kind;
  logic [63:0] m_inv_h, m_scale, m_stiff, m_inv_rho0;
  logic [63:0] m_sum;
  bit          m_clip_seen;
  bit          clip_acc;

  particle_res_t due_results[$];
  int  err_cnt = 0;
  int  wdog = 0;
  bit  stim_done = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    err_cnt++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b,
                                          input int sh, input logic [63:0] maxv);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    if (p > {64'd0, maxv}) begin
      clip_acc = 1;
      return maxv;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] fx_power(input logic [63:0] u, input int p);
    logic [63:0] r;
    r = u;
    for (int i = 1; i < p; i++) r = (r * u) >> 16;
    return r;
  endfunction

  function automatic logic [63:0] spline_shape(input logic [63:0] q);
    longint s;
    s = 0;
    if (m_kind == KIND_CUBIC) begin
      if (q < ONE)
        s = longint'(fx_power(2 * ONE - q, 3)) - 4 * longint'(fx_power(ONE - q, 3));
      else if (q < 2 * ONE)
        s = longint'(fx_power(2 * ONE - q, 3));
    end else begin
      if (q <= ONE)
        s = longint'(fx_power(3 * ONE - q, 5)) - 6 * longint'(fx_power(2 * ONE - q, 5))
            + 15 * longint'(fx_power(ONE - q, 5));
      else if (q <= 2 * ONE)
        s = longint'(fx_power(3 * ONE - q, 5)) - 6 * longint'(fx_power(2 * ONE - q, 5));
      else if (q <= 3 * ONE)
        s = longint'(fx_power(3 * ONE - q, 5));
    end
    return (s > 0) ? 64'(s) : 64'd0;
  endfunction

  function automatic logic [63:0] mag32(input logic [31:0] v);
    return v[31] ? (64'd1 << 32) - {32'd0, v} : {32'd0, v};
  endfunction

  // returns 1 when the neighbour closes a particle
  function automatic bit density_pressure_predict(input logic [31:0] ox, oy, oz, mass,
                                                  input logic last,
                                                  output particle_res_t r);
    logic [63:0] ax, ay, az, sq, root, cand, q, w, contrib, rho, ratio, r7, pres;
    ax = mag32(ox); ay = mag32(oy); az = mag32(oz);
    sq = ax * ax + ay * ay + az * az;
    root = 0;
    for (int i = 0; i < 32; i++) begin
      cand = root | (64'd1 << (31 - i));
      if (cand * cand <= sq) root = cand;
    end
    q = (root * m_inv_h) >> 16;
    w = (spline_shape(q) * m_scale) >> 24;
    clip_acc = m_clip_seen;
    contrib = mul_sat({32'd0, mass}, w, 16, SUM_MAX);
    if (contrib > SUM_MAX - m_sum) begin
      m_sum = SUM_MAX;
      clip_acc = 1;
    end else begin
      m_sum = m_sum + contrib;
    end
    m_clip_seen = clip_acc;
    if (!last) return 0;
    rho = m_sum;
    ratio = mul_sat(rho, m_inv_rho0, 16, BIG63_MAX);
    r7 = ratio;
    for (int i = 0; i < 6; i++) r7 = mul_sat(r7, ratio, 16, BIG63_MAX);
    if (r7 >= ONE) pres = mul_sat(m_stiff, r7 - ONE, 16, POS47_MAX);
    else pres = 64'd0 - ((m_stiff * (ONE - r7)) >> 16);
    r.density = rho[47:0];
    r.pressure = pres[47:0];
    r.saturated = clip_acc;
    m_sum = 0;
    m_clip_seen = 0;
    return 1;
  endfunction

  function automatic int pick_gap();
    int c;
    c = $urandom_range(0, 99);
    if (c < 55) return 0;
    if (c < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_KIND:     m_kind = val[0];
      REG_INV_H:    m_inv_h = {32'd0, val};
      REG_SCALE:    m_scale = {32'd0, val};
      REG_STIFF:    m_stiff = {32'd0, val};
      REG_INV_RHO0: m_inv_rho0 = {32'd0, val};
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (IDLE_WAIT) @(negedge clk_i);
  endtask

  task automatic send_neighbour(input logic [31:0] ox, oy, oz, mass, input logic last,
                                input bit typed, input particle_res_t typed_res);
    int gap;
    particle_res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      nb_ch.valid = 0;
      repeat (gap) @(negedge clk_i);
    end
    nb_ch.valid = 1;
    nb_ch.offset_x = ox; nb_ch.offset_y = oy; nb_ch.offset_z = oz;
    nb_ch.neighbour_mass = mass; nb_ch.last_neighbour = last;
    do @(posedge clk_i); while (!nb_ch.ready);
    if (density_pressure_predict(ox, oy, oz, mass, last, r))
      due_results.insert(due_results.size(), typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic finish_phase();
    nb_ch.valid = 0;
    wait_idle();
  endtask

  function automatic logic [31:0] rand_offset(input int span);
    if ($urandom_range(0, 99) < 12) return $urandom;
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [31:0] rand_mass();
    int c;
    c = $urandom_range(0, 99);
    if (c < 10) return $urandom;
    if (c < 15) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom_range(0, 8 * 65536);
  endfunction

  task automatic random_config(input int ph);
    logic [31:0] v;
    apb_write(REG_KIND, 32'($urandom_range(0, 1)));
    case (ph % 6)
      0: v = 32'd65536;
      1: v = 32'd0;
      2: v = 32'hFFFF_FFFF;
      default: v = $urandom_range(16384, 262144);
    endcase
    apb_write(REG_INV_H, v);
    case (ph % 5)
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      default: v = $urandom_range(1 << 22, 1 << 26);
    endcase
    apb_write(REG_SCALE, v);
    case (ph % 4)
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    apb_write(REG_STIFF, v);
    case (ph % 7)
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      2: v = $urandom;
      default: v = $urandom_range(1 << 10, 1 << 16);
    endcase
    apb_write(REG_INV_RHO0, v);
  endtask

  // directed table; typed rows carry results that follow directly from reset values
  nb_row_t rows[] = '{
    '{1'b0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b1, 1'b1,
      48'd262144, 48'd1073676288, 1'b0},
    '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1,
      48'd0, 48'hFFFF_FFFF_0000, 1'b0},
    '{1'b0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1,
      48'h3_FFFF_FFFC, 48'h7FFF_FFFF_FFFF, 1'b1},
    '{1'b0, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 1'b0, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b0, 32'd0, 32'hFFFF_0000, 32'd0, 32'h0001_0000, 1'b0, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b0, 32'd0, 32'd0, 32'h0002_0000, 32'h0001_0000, 1'b0, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b0, 32'h0001_FFFF, 32'd0, 32'd0, 32'h0002_0000, 1'b1, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
      1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1,
      1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b0, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000, 32'h0000_8000, 1'b1,
      1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b1, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b1, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b1, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 1'b0, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b1, 32'd0, 32'h0002_0000, 32'd0, 32'h0001_0000, 1'b0, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b1, 32'd0, 32'd0, 32'h0003_0000, 32'h0001_0000, 1'b0, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b1, 32'hFFFD_0000, 32'd0, 32'd0, 32'h0001_0000, 1'b0, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b1, 32'h0003_0001, 32'd0, 32'd0, 32'h0001_0000, 1'b1, 1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b1, 32'h0000_C000, 32'h0000_C000, 32'd0, 32'hFFFF_FFFF, 1'b1,
      1'b0, 48'd0, 48'd0, 1'b0},
    '{1'b1, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1,
      1'b0, 48'd0, 48'd0, 1'b0}
  };

  // result sink: random stalls
  initial begin
    int stall;
    stall = 0;
    res_ch.ready = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        res_ch.ready = 0;
        stall--;
      end else begin
        res_ch.ready = 1;
        if ($urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    particle_res_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        report("unexpected result beat", {16'd0, res_ch.density}, 64'd0);
      end else begin
        e = due_results.pop_front();
        if (res_ch.density !== e.density)
          report("density", 64'(res_ch.density), 64'(e.density));
        if (res_ch.pressure !== e.pressure)
          report("pressure", 64'(res_ch.pressure), 64'(e.pressure));
        if (res_ch.saturated !== e.saturated)
          report("saturated", 64'(res_ch.saturated), 64'(e.saturated));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((nb_ch.valid && nb_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    particle_res_t tr;
    particle_res_t none;
    int plen, sent, ph;
    nb_ch.valid = 0;
    nb_ch.offset_x = 0; nb_ch.offset_y = 0; nb_ch.offset_z = 0;
    nb_ch.neighbour_mass = 0; nb_ch.last_neighbour = 0;
    none = '{48'd0, 48'd0, 1'b0};
    m_kind = KIND_RST; m_inv_h = {32'd0, INV_H_RST}; m_scale = {32'd0, SCALE_RST};
    m_stiff = {32'd0, STIFF_RST}; m_inv_rho0 = {32'd0, INV_RHO0_RST};
    m_sum = 0; m_clip_seen = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind != m_kind) begin
        finish_phase();
        apb_write(REG_KIND, {31'd0, rows[i].kind});
      end
      tr = '{rows[i].rho, rows[i].pres, rows[i].sat};
      send_neighbour(rows[i].ox, rows[i].oy, rows[i].oz, rows[i].mass, rows[i].last,
                     rows[i].typed, tr);
    end
    finish_phase();

    sent = 0;
    ph = 0;
    while (sent < 1900) begin
      random_config(ph);
      repeat (40) begin
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        for (int k = 0; k < plen; k++) begin
          send_neighbour(rand_offset(4 * 65536), rand_offset(4 * 65536),
                         rand_offset(4 * 65536), rand_mass(), k == plen - 1, 0, none);
          sent++;
        end
      end
      finish_phase();
      ph++;
    end

    apb_write(REG_INV_H, INV_H_RST);
    apb_write(REG_SCALE, SCALE_RST);
    apb_write(REG_STIFF, STIFF_RST);
    apb_write(REG_INV_RHO0, INV_RHO0_RST);
    apb_write(REG_KIND, {31'd0, KIND_RST});
    send_neighbour(32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b1, 0, none);
    finish_phase();

    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sphdp_pkg.sv
design/sphdp_in_if.sv
design/sphdp_out_if.sv
design/sphdp_front.sv
design/sphdp_fifo.sv
design/sphdp_mul.sv
design/sphdp_back.sv
design/sph_density_and_pressure_unit.sv
sim/tb_top.sv
